// ----- rtl/dam_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dam_pkg
// Shared types and constants for the decimal accumulator machine.
// ----------------------------------------------------------------------------
package dam_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned PcW     = 14;
  localparam int unsigned OpW     = 4;
  localparam int unsigned AddrBase = 10000;
  localparam int unsigned ReadMod  = 1000000;

  // Reciprocal of the read modulus, scaled by 2^ReadShift and rounded up.
  // Exact for every dividend magnitude up to 2^31.
  localparam logic [30:0] ReadRecip = 31'd1125899907;
  localparam int unsigned ReadShift = 50;
  localparam int unsigned ReadQuoW  = 12;

  // Item functions.
  localparam logic [1:0] FUNC_WRITE   = 2'd0;
  localparam logic [1:0] FUNC_RESTART = 2'd1;
  localparam logic [1:0] FUNC_STEP    = 2'd2;
  localparam logic [1:0] FUNC_UNUSED  = 2'd3;

  // Instruction opcodes.
  localparam logic [OpW-1:0] OP_ADD   = 4'd1;
  localparam logic [OpW-1:0] OP_SUB   = 4'd2;
  localparam logic [OpW-1:0] OP_MUL   = 4'd3;
  localparam logic [OpW-1:0] OP_DIV   = 4'd4;
  localparam logic [OpW-1:0] OP_LOAD  = 4'd5;
  localparam logic [OpW-1:0] OP_STORE = 4'd6;
  localparam logic [OpW-1:0] OP_READ  = 4'd7;
  localparam logic [OpW-1:0] OP_SHOW  = 4'd8;
  localparam logic [OpW-1:0] OP_JMP   = 4'd9;
  localparam logic [OpW-1:0] OP_JNEG  = 4'd10;
  localparam logic [OpW-1:0] OP_JZERO = 4'd11;
  localparam logic [OpW-1:0] OP_JPOS  = 4'd12;
  localparam logic [OpW-1:0] OP_HALT  = 4'd13;
  localparam logic [OpW-1:0] OP_NONE  = 4'd14;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_DECODE,
    ST_OPERAND,
    ST_DIVIDE,
    ST_DONE
  } dam_state_e;

  // Per-item status flags reported with the result.
  typedef struct packed {
    logic accepted;
    logic shown_valid;
    logic read_taken;
    logic fault;
  } dam_status_t;

  // Base value of an opcode field, opcode times the address base.
  function automatic logic [WordW-1:0] op_base(input logic [OpW-1:0] op);
    logic [WordW-1:0] r;
    r = WordW'(op) * WordW'(AddrBase);
    return r;
  endfunction

endpackage : dam_pkg
`default_nettype wire

// ----- rtl/dam_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dam_mem
// Word memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dam_mem #(
  parameter int unsigned Depth = 10000,
  parameter int unsigned AW    = 14
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [AW-1:0]             waddr_i,
  input  wire logic [dam_pkg::WordW-1:0] wdata_i,
  input  wire logic [AW-1:0]             raddr_i,
  output      logic [dam_pkg::WordW-1:0] rdata_o
);
  import dam_pkg::*;

  logic [WordW-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule : dam_mem
`default_nettype wire

// ----- rtl/dam_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dam_div
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module dam_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [dam_pkg::WordW-1:0] dividend_i,
  input  wire logic [dam_pkg::WordW-1:0] divisor_i,
  output      logic                      done_o,
  output      logic [dam_pkg::WordW-1:0] quotient_o
);
  import dam_pkg::*;

  logic             busy_q, done_q, negq_q;
  logic [4:0]       cnt_q;
  logic [WordW-1:0] rem_q, quo_q, ub_q;
  logic [WordW:0]   shifted;
  logic             fits;

  // Shift in the next dividend bit and try the subtraction.
  assign shifted = {rem_q, quo_q[WordW-1]};
  assign fits    = shifted >= {1'b0, ub_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd31;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand magnitudes and the running remainder.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= dividend_i[WordW-1] ? (~dividend_i + 1'b1) : dividend_i;
      ub_q   <= divisor_i[WordW-1] ? (~divisor_i + 1'b1) : divisor_i;
      rem_q  <= '0;
      negq_q <= dividend_i[WordW-1] ^ divisor_i[WordW-1];
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= WordW'(shifted - {1'b0, ub_q});
      end else begin
        rem_q <= shifted[WordW-1:0];
      end
      quo_q <= {quo_q[WordW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = negq_q ? (~quo_q + 1'b1) : quo_q;

endmodule : dam_div
`default_nettype wire

// ----- rtl/decimal_accumulator_machine_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A write, restart, unknown or halted step goes from accept to its result in ST_DONE;
// an executed instruction passes fetch read, decode, operand read and execute.
// A divide by a nonzero operand also waits for the serial divider before its result.
// The next item is taken in the cycle after a result is loaded; output stalls hold
// the result back. After reset the memory is swept to zero, one word a cycle,
// while in_stall_o stays high.
// ----------------------------------------------------------------------------
// decimal_accumulator_machine_step
// One-accumulator decimal machine: memory writes, restart and single steps.
// ----------------------------------------------------------------------------
module decimal_accumulator_machine_step #(
  parameter int unsigned MEM_WORDS = 10000
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output      logic                      in_stall_o,
  input  wire logic [1:0]                func_i,
  input  wire logic [15:0]               location_i,
  input  wire logic signed [31:0]        contents_i,
  input  wire logic signed [31:0]        read_value_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_stall_i,
  output      logic                      accepted_o,
  output      logic                      shown_valid_o,
  output      logic signed [31:0]        shown_value_o,
  output      logic                      read_taken_o,
  output      logic                      halted_o,
  output      logic                      fault_o,
  output      logic [13:0]               program_counter_o,
  output      logic signed [31:0]        acc_value_o
);
  import dam_pkg::*;

  localparam int unsigned AW = $clog2(MEM_WORDS);

  dam_state_e          state_q, state_d;
  logic [AW-1:0]       clr_q;
  logic [WordW-1:0]    acc_q, rval_q, shown_q;
  logic [PcW-1:0]      pc_q, addr_q;
  logic                stopped_q;
  logic [OpW-1:0]      op_q;
  dam_status_t         status_q;
  logic                out_valid_q;
  logic [ReadQuoW-1:0] rquo_q;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [WordW-1:0] mem_wdata, mem_rdata;
  logic             div_start, div_done;
  logic [WordW-1:0] div_a, div_b, div_q;

  logic [OpW-1:0]   op_dec;
  logic [WordW-1:0] addr_full;
  logic             addr_ok;
  logic [WordW-1:0] operand;
  logic [WordW-1:0] product;
  logic [PcW-1:0]   pc_next;
  logic             out_free;
  logic [WordW-1:0] rmag, rem_mag, read_rem;
  logic [62:0]      rprod;

  // Word memory and serial divider.
  dam_mem #(.Depth(MEM_WORDS), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  dam_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_a),
    .divisor_i   (div_b),
    .done_o      (div_done),
    .quotient_o  (div_q)
  );

  // Opcode from the fetched word: independent threshold compares.
  always_comb begin
    op_dec = '0;
    for (int k = 1; k <= 14; k++) begin
      if ($signed(mem_rdata) >= $signed(WordW'(k * AddrBase))) begin
        op_dec = OpW'(k);
      end
    end
  end
  assign addr_full = mem_rdata - op_base(op_dec);

  assign addr_ok  = 32'(addr_q) < MEM_WORDS;
  assign operand  = addr_ok ? mem_rdata : '0;
  assign product  = acc_q * operand;
  assign out_free = !out_valid_q || !out_stall_i;

  // Read value modulo the read modulus: the quotient comes from a reciprocal
  // multiply during fetch, the remainder is formed in the operand stage and
  // takes the sign of the read value.
  assign rmag     = rval_q[WordW-1] ? (~rval_q + 1'b1) : rval_q;
  assign rprod    = 63'(rmag) * 63'(ReadRecip);
  assign rem_mag  = rmag - WordW'(rquo_q) * WordW'(ReadMod);
  assign read_rem = rval_q[WordW-1] ? (~rem_mag + 1'b1) : rem_mag;

  // Next program counter from the operand stage.
  always_comb begin
    pc_next = pc_q + 1'b1;
    case (op_q)
      OP_JMP:   pc_next = addr_q;
      OP_JNEG:  if (acc_q[WordW-1]) pc_next = addr_q;
      OP_JZERO: if (acc_q == '0) pc_next = addr_q;
      OP_JPOS:  if (!acc_q[WordW-1] && acc_q != '0) pc_next = addr_q;
      OP_HALT:  pc_next = PcW'(MEM_WORDS);
      default:  pc_next = pc_q + 1'b1;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and memory and divider controls.
  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_waddr = addr_q[AW-1:0];
    mem_wdata = acc_q;
    mem_raddr = pc_q[AW-1:0];
    div_start = 1'b0;
    div_a     = acc_q;
    div_b     = operand;
    in_stall_o = state_q != ST_IDLE;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (32'(clr_q) == MEM_WORDS - 1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (func_i == FUNC_WRITE) begin
            mem_we    = 32'(location_i) < MEM_WORDS;
            mem_waddr = location_i[AW-1:0];
            mem_wdata = contents_i;
            state_d   = ST_DONE;
          end else if (func_i == FUNC_STEP && !stopped_q && 32'(pc_q) < MEM_WORDS) begin
            state_d = ST_FETCH;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_DECODE;
      end
      ST_DECODE: begin
        mem_raddr = addr_q[AW-1:0];
        state_d   = ST_OPERAND;
      end
      ST_OPERAND: begin
        if (op_q == OP_STORE) begin
          mem_we = addr_ok;
        end
        if (op_q == OP_READ) begin
          mem_we    = addr_ok;
          mem_wdata = read_rem;
        end
        if (op_q == OP_DIV && operand != '0) begin
          div_start = 1'b1;
          state_d   = ST_DIVIDE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Machine control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      acc_q       <= '0;
      pc_q        <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      out_valid_q <= (state_q == ST_DONE && out_free) || (out_valid_q && out_stall_i);
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && func_i == FUNC_RESTART) begin
            pc_q      <= '0;
            stopped_q <= 1'b0;
          end
        end
        ST_OPERAND: begin
          pc_q <= pc_next;
          if (op_q == OP_HALT || 32'(pc_next) >= MEM_WORDS) stopped_q <= 1'b1;
          case (op_q)
            OP_ADD:  acc_q <= acc_q + operand;
            OP_SUB:  acc_q <= acc_q - operand;
            OP_MUL:  acc_q <= product;
            OP_LOAD: acc_q <= operand;
            default: acc_q <= acc_q;
          endcase
        end
        ST_DIVIDE: begin
          if (div_done && op_q == OP_DIV) acc_q <= div_q;
        end
        default: begin
        end
      endcase
    end
  end

  // Item payload and per-item status.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          rval_q   <= read_value_i;
          shown_q  <= '0;
          status_q <= '{accepted: func_i == FUNC_WRITE && 32'(location_i) < MEM_WORDS,
                        default: 1'b0};
        end
      end
      ST_FETCH: begin
        op_q   <= op_dec;
        addr_q <= addr_full[PcW-1:0];
        rquo_q <= rprod[ReadShift +: ReadQuoW];
      end
      ST_OPERAND: begin
        if (op_q == OP_SHOW) begin
          status_q.shown_valid <= 1'b1;
          shown_q              <= operand;
        end
        if (op_q == OP_READ) status_q.read_taken <= 1'b1;
        if (op_q == OP_DIV && operand == '0) status_q.fault <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Result register, loaded as the item leaves.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      accepted_o        <= status_q.accepted;
      shown_valid_o     <= status_q.shown_valid;
      shown_value_o     <= shown_q;
      read_taken_o      <= status_q.read_taken;
      fault_o           <= status_q.fault;
      halted_o          <= stopped_q;
      program_counter_o <= pc_q;
      acc_value_o       <= acc_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // The clearing sweep blocks items.
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> in_stall_o) else $error("item taken during clear");

  // A running machine never reports a counter past the memory.
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !halted_o |-> 32'(program_counter_o) < MEM_WORDS)
    else $error("counter out of range while running");

  // At most one instruction effect per item.
  a_one_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({fault_o, shown_valid_o, read_taken_o, accepted_o}) <= 1)
    else $error("conflicting status flags");

  // The divider finishes only while an item waits on it.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIVIDE) else $error("stray divider result");

endmodule : decimal_accumulator_machine_step
`default_nettype wire

// ----- test/tb_decimal_accumulator_machine_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_accumulator_machine_step
// Drives memory writes, restarts and single steps into the decimal machine and
// compares each result with the bench's behavioral machine or its typed row.
// A short directed table comes first, then random programs with noise.
// ----------------------------------------------------------------------------
module tb_decimal_accumulator_machine_step;
  import dam_pkg::*;

  localparam int MemWords  = 10000;
  localparam int IdleLimit = 40000;
  localparam int RandItems = 550;

  typedef struct packed {
    logic        accepted;
    logic        shown_valid;
    logic [31:0] shown_value;
    logic        read_taken;
    logic        halted;
    logic        fault;
    logic [13:0] pc;
    logic [31:0] acc;
  } machine_result_t;

  typedef struct {
    logic [1:0]      func;
    logic [15:0]     location;
    logic [31:0]     contents;
    logic [31:0]     read_value;
    bit              typed;
    machine_result_t result;
  } stim_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0] func;
  logic [15:0] location;
  logic signed [31:0] contents, read_value;
  logic accepted, shown_valid, read_taken, halted, fault;
  logic signed [31:0] shown_value, acc_value;
  logic [13:0] program_counter;

  // Side information travelling with the driven item.
  bit              cur_typed;
  machine_result_t cur_result;

  // Machine state of the bench copy.
  logic [31:0] word_mem [0:MemWords-1];
  logic [31:0] acc_q;
  logic [13:0] pc_q;
  logic        stopped_q;

  machine_result_t pending_q[$];
  stim_row_t       rows[$];
  int errors;
  int idle_cycles;
  bit quiet;

  decimal_accumulator_machine_step #(.MEM_WORDS(MemWords)) u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .func_i(func), .location_i(location), .contents_i(contents),
    .read_value_i(read_value),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .accepted_o(accepted), .shown_valid_o(shown_valid), .shown_value_o(shown_value),
    .read_taken_o(read_taken), .halted_o(halted), .fault_o(fault),
    .program_counter_o(program_counter), .acc_value_o(acc_value)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Executes one item on the bench copy of the machine.
  function automatic machine_result_t step_machine(logic [1:0] f, logic [15:0] loc,
                                                   logic [31:0] c, logic [31:0] rv);
    machine_result_t r;
    longint nxt, w, op, ad, a, m;
    r = '0;
    case (f)
      FUNC_WRITE: begin
        if (loc < MemWords) begin
          word_mem[loc] = c;
          r.accepted = 1'b1;
        end
      end
      FUNC_RESTART: begin
        pc_q = '0;
        stopped_q = 1'b0;
      end
      FUNC_STEP: begin
        if (!stopped_q) begin
          nxt = longint'(pc_q) + 1;
          if (pc_q >= MemWords) begin
            nxt = pc_q;
          end else begin
            w = longint'($signed(word_mem[pc_q]));
            if (w != 0) begin
              op = w / 10000;
              ad = w % 10000;
              a = longint'($signed(acc_q));
              m = (ad >= 0 && ad < MemWords) ? longint'($signed(word_mem[ad])) : 0;
              case (op)
                OP_ADD:  acc_q = acc_q + m[31:0];
                OP_SUB:  acc_q = acc_q - m[31:0];
                OP_MUL:  acc_q = acc_q * m[31:0];
                OP_DIV: begin
                  if (m == 0) r.fault = 1'b1;
                  else acc_q = 32'(a / m);
                end
                OP_LOAD: acc_q = m[31:0];
                OP_STORE: if (ad >= 0 && ad < MemWords) word_mem[ad] = acc_q;
                OP_READ: begin
                  if (ad >= 0 && ad < MemWords)
                    word_mem[ad] = 32'(longint'($signed(rv)) % 1000000);
                  r.read_taken = 1'b1;
                end
                OP_SHOW: begin
                  r.shown_valid = 1'b1;
                  r.shown_value = m[31:0];
                end
                OP_JMP:   nxt = ad;
                OP_JNEG:  if (a < 0) nxt = ad;
                OP_JZERO: if (a == 0) nxt = ad;
                OP_JPOS:  if (a > 0) nxt = ad;
                OP_HALT: begin
                  nxt = MemWords;
                  stopped_q = 1'b1;
                end
                default: ;
              endcase
            end
          end
          pc_q = nxt[13:0];
          if (nxt >= MemWords) stopped_q = 1'b1;
        end
      end
      default: ;
    endcase
    r.halted = stopped_q;
    r.pc = pc_q;
    r.acc = acc_q;
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // Stimulus driver; the valid stays high across back-to-back items.
  task automatic send_item(logic [1:0] f, logic [15:0] loc, logic [31:0] c,
                           logic [31:0] rv, bit typed, machine_result_t res);
    if (!quiet && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 40);
    end
    in_valid <= 1'b1;
    func <= f;
    location <= loc;
    contents <= c;
    read_value <= rv;
    cur_typed <= typed;
    cur_result <= res;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_plain(logic [1:0] f, logic [15:0] loc, logic [31:0] c, logic [31:0] rv);
    send_item(f, loc, c, rv, 1'b0, '0);
  endtask

  function automatic machine_result_t typed_result(logic acc_ok, logic [13:0] pc);
    machine_result_t r;
    r = '0;
    r.accepted = acc_ok;
    r.pc = pc;
    return r;
  endfunction

  function automatic void add_row(logic [1:0] f, logic [15:0] loc, logic [31:0] c,
                                  logic [31:0] rv, bit typed, machine_result_t res);
    stim_row_t row;
    row.func = f;
    row.location = loc;
    row.contents = c;
    row.read_value = rv;
    row.typed = typed;
    row.result = res;
    rows.push_back(row);
  endfunction

  function automatic logic [31:0] make_word();
    int op, ad;
    if ($urandom_range(0, 99) < 5) return $urandom;
    op = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 13);
    ad = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 40) : $urandom_range(0, 9999);
    if ($urandom_range(0, 49) == 0) ad = $urandom_range(9990, 9999);
    return 32'(op * 10000 + ad);
  endfunction

  function automatic logic [31:0] make_data();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return $urandom;
      default: return 32'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  // Occasional noise: bad func, out-of-range writes, wide writes, plain steps.
  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_plain(FUNC_UNUSED, 16'($urandom), $urandom, $urandom);
      1: send_plain(FUNC_WRITE, 16'($urandom_range(MemWords, 65535)), $urandom, $urandom);
      2: send_plain(FUNC_WRITE, 16'($urandom_range(0, MemWords - 1)), $urandom, $urandom);
      default: send_plain(FUNC_STEP, 16'($urandom), $urandom, $urandom);
    endcase
  endtask

  // Result checking and expectation bookkeeping.
  always @(posedge clk) begin
    machine_result_t e, got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{accepted, shown_valid, shown_value, read_taken, halted, fault,
              program_counter, acc_value};
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result item", 1, 0);
      end else begin
        e = pending_q.pop_front();
        if (got.accepted != e.accepted) report_mismatch("accepted", got.accepted, e.accepted);
        if (got.shown_valid != e.shown_valid)
          report_mismatch("shown_valid", got.shown_valid, e.shown_valid);
        if (got.shown_value != e.shown_value)
          report_mismatch("shown_value", $signed(got.shown_value), $signed(e.shown_value));
        if (got.read_taken != e.read_taken)
          report_mismatch("read_taken", got.read_taken, e.read_taken);
        if (got.halted != e.halted) report_mismatch("halted", got.halted, e.halted);
        if (got.fault != e.fault) report_mismatch("fault", got.fault, e.fault);
        if (got.pc != e.pc) report_mismatch("program_counter", got.pc, e.pc);
        if (got.acc != e.acc) report_mismatch("acc_value", $signed(got.acc), $signed(e.acc));
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      e = step_machine(func, location, contents, read_value);
      pending_q.push_back(cur_typed ? cur_result : e);
    end
  end

  // Receiver stalls and the watchdog on handshake progress.
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 7);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb_decimal_accumulator_machine_step failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int sent, n, k;
    errors = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    func = FUNC_WRITE;
    location = '0;
    contents = '0;
    read_value = '0;
    cur_typed = 1'b0;
    cur_result = '0;
    for (int i = 0; i < MemWords; i++) word_mem[i] = '0;
    acc_q = '0;
    pc_q = '0;
    stopped_q = 1'b0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: values right after reset and the edges of location.
    add_row(FUNC_STEP, 16'd0, 32'd0, 32'd0, 1'b1, typed_result(1'b0, 14'd1));
    add_row(FUNC_WRITE, 16'd10000, 32'd5, 32'd0, 1'b1, typed_result(1'b0, 14'd1));
    add_row(FUNC_WRITE, 16'hffff, 32'hffff_ffff, 32'd0, 1'b1, typed_result(1'b0, 14'd1));
    add_row(FUNC_WRITE, 16'd9999, 32'h7fff_ffff, 32'd0, 1'b1, typed_result(1'b1, 14'd1));
    // A small program touching divide overflow, divide by zero, read and display.
    add_row(FUNC_WRITE, 16'd10, 32'h8000_0000, 32'd0, 1'b0, '0);
    add_row(FUNC_WRITE, 16'd11, 32'hffff_ffff, 32'd0, 1'b0, '0);
    add_row(FUNC_WRITE, 16'd1, 32'd50010, 32'd0, 1'b0, '0);
    add_row(FUNC_WRITE, 16'd2, 32'd40011, 32'd0, 1'b0, '0);
    add_row(FUNC_WRITE, 16'd3, 32'd40012, 32'd0, 1'b0, '0);
    add_row(FUNC_WRITE, 16'd4, 32'd19999, 32'd0, 1'b0, '0);
    add_row(FUNC_WRITE, 16'd5, 32'd70021, 32'd0, 1'b0, '0);
    add_row(FUNC_WRITE, 16'd6, 32'd80021, 32'd0, 1'b0, '0);
    add_row(FUNC_WRITE, 16'd7, 32'd99999, 32'd0, 1'b0, '0);
    add_row(FUNC_RESTART, 16'd0, 32'd0, 32'd0, 1'b0, '0);
    for (int i = 0; i < 8; i++)
      add_row(FUNC_STEP, 16'd0, 32'd0, (i == 5) ? 32'h8000_0000 : 32'h7fff_ffff, 1'b0, '0);
    add_row(FUNC_STEP, 16'd0, 32'd0, 32'd0, 1'b0, '0);
    add_row(FUNC_STEP, 16'd0, 32'd0, 32'd0, 1'b0, '0);
    add_row(FUNC_UNUSED, 16'd0, 32'd0, 32'd0, 1'b0, '0);
    foreach (rows[i])
      send_item(rows[i].func, rows[i].location, rows[i].contents, rows[i].read_value,
                rows[i].typed, rows[i].result);

    // Random programs: load code and data, restart, then single-step with noise.
    sent = 0;
    while (sent < RandItems) begin
      quiet = (sent > 200 && sent < 300);
      n = $urandom_range(4, 16);
      for (int i = 0; i < n; i++) begin
        send_plain(FUNC_WRITE, 16'(i), make_word(), $urandom);
        sent++;
      end
      k = $urandom_range(2, 8);
      for (int i = 0; i < k; i++) begin
        send_plain(FUNC_WRITE, 16'($urandom_range(16, 40)), make_data(), $urandom);
        sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_plain(FUNC_WRITE, 16'($urandom_range(9990, 9999)), make_word(), $urandom);
        sent++;
      end
      send_plain(FUNC_RESTART, 16'($urandom), $urandom, $urandom);
      sent++;
      k = $urandom_range(10, 30);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 99) < 12) send_noise();
        else send_plain(FUNC_STEP, 16'($urandom), $urandom,
                        make_data() ^ $urandom_range(0, 3));
        sent++;
      end
    end
    in_valid <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("tb_decimal_accumulator_machine_step passed");
    end else begin
      $display("tb_decimal_accumulator_machine_step failed");
    end
    $finish;
  end

endmodule
